@@ rtl/core/iprct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprct_pkg
// shared types and constants of the ip range country table
// ----------------------------------------------------------------------------
package iprct_pkg;

    localparam int TableDepth = 4096;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int CountW     = AddrW + 1;
    // entry: flag, long code, short code, end, start
    localparam int EntryW     = 8 + 24 + 16 + 32 + 32;

    typedef logic [1:0] t_kind;
    localparam t_kind KindInsert   = 2'd0;
    localparam t_kind KindLookup   = 2'd1;
    localparam t_kind KindClear    = 2'd2;
    localparam t_kind KindReserved = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status StInserted = 3'd0;
    localparam t_status StReplaced = 3'd1;
    localparam t_status StFull     = 3'd2;
    localparam t_status StCleared  = 3'd3;
    localparam t_status StHit      = 3'd4;
    localparam t_status StMiss     = 3'd5;

    // tdata widths, already whole bytes
    localparam int InW  = 32 + 32 + 32 + 16 + 24 + 8;
    localparam int OutW = 16 + 24 + 8 + 32 + 32;

    typedef struct packed {
        logic [7:0]  flag;
        logic [23:0] code3;
        logic [15:0] code2;
        logic [31:0] r_end;
        logic [31:0] start;
    } t_entry;

endpackage

@@ rtl/core/ip_range_country_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_range_country_table
// sorted ipv4 range table with binary-search lookup and shifting insert
// ----------------------------------------------------------------------------
// channel   dir  tuser    tdata fields (lsb up)
// s_axis    in   kind     range_start, range_end, query_ip, code_two,
//                         code_three, flag_number
// m_axis    out  status   hit_code_two, hit_code_three, hit_flag, hit_start,
//                         hit_end
// cfg       in   -        index 0 lookup_enabled, index 1 flags_enabled
//
// one word at a time; the table lives in one memory with a registered read.
// a search takes up to 13 probes for a full table. a replace then writes in
// place; an insert in front of n entries first moves each of them up one
// place, then writes the new entry. clear and early miss skip the search.
// synchronous active-low reset empties the table.
// the result register parts the two sides: a word is taken whenever the core
// is idle, and only the finished result waits while the output is held.
// ----------------------------------------------------------------------------
module ip_range_country_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // kind
    input  iprct_pkg::t_kind         s_axis_tuser,
    // range_start, range_end, query_ip, code_two, code_three, flag_number
    input  logic [iprct_pkg::InW-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // status
    output iprct_pkg::t_status       m_axis_tuser,
    // hit_code_two, hit_code_three, hit_flag, hit_start, hit_end
    output logic [iprct_pkg::OutW-1:0] m_axis_tdata,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic                     i_cfg_data
);
    import iprct_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROBE = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_MOVRD = 7'b0001000,
        S_MOVWR = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_entry mem [TableDepth];
    t_entry r_rd;

    t_state r_state;
    logic   r_lk_en, r_fl_en;
    logic [CountW-1:0] r_count, r_lo, r_hi, r_mv;
    t_kind  r_kind;
    logic [31:0] r_key;
    t_entry r_new;
    logic   r_probe_wait;

    // finished result waiting for the output register
    t_status r_res_st;
    t_entry  r_res;

    logic             r_ovalid;
    t_status          r_ostat;
    logic [OutW-1:0]  r_odata;

    // memory port
    logic              mem_we;
    logic [AddrW-1:0]  mem_wa, mem_ra;
    t_entry            mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    wire [CountW-1:0] mid = r_lo + ((r_hi - r_lo) >> 1);
    wire go_right = (r_kind == KindLookup) ? (r_rd.start <= r_key) : (r_rd.start < r_key);
    wire take = s_axis_tvalid && s_axis_tready;
    // take a word whenever the core is idle, the output register holds
    // the previous result on its own
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tdata  = r_odata;

    wire t_kind     in_kind  = s_axis_tuser;
    wire [31:0]     in_start = s_axis_tdata[31:0];
    wire [31:0]     in_end   = s_axis_tdata[63:32];
    wire [31:0]     in_q     = s_axis_tdata[95:64];
    wire [15:0]     in_c2    = s_axis_tdata[111:96];
    wire [23:0]     in_c3    = s_axis_tdata[135:112];
    wire [7:0]      in_fl    = s_axis_tdata[143:136];
    wire [31:0]     q_sw     = {in_q[7:0], in_q[15:8], in_q[23:16], in_q[31:24]};

    logic [CountW-1:0] pos_m1;
    assign pos_m1 = r_lo - 1'b1;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_mv[AddrW-1:0];
        mem_wd = r_rd;
        mem_ra = mid[AddrW-1:0];
        unique case (r_state)
            S_CHECK: mem_ra = (r_kind == KindLookup) ? pos_m1[AddrW-1:0]
                                                     : r_lo[AddrW-1:0];
            S_MOVRD: mem_ra = pos_m1[AddrW-1:0] + r_mv[AddrW-1:0] - r_lo[AddrW-1:0];
            S_MOVWR: begin
                mem_we = 1'b1;
                mem_wa = r_mv[AddrW-1:0];
            end
            S_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_lo[AddrW-1:0];
                mem_wd = r_new;
            end
            default: ;
        endcase
    end

    task automatic emit(input t_status st, input t_entry e);
        r_res_st <= st;
        r_res    <= e;
        r_state  <= S_DONE;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lk_en  <= 1'b0;
            r_fl_en  <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_probe_wait <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index) r_fl_en <= i_cfg_data;
                else             r_lk_en <= i_cfg_data;
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (take) begin
                    r_kind <= in_kind;
                    r_new  <= '{flag: r_fl_en ? in_fl : 8'd0, code3: in_c3,
                               code2: in_c2, r_end: in_end, start: in_start};
                    r_lo <= '0;
                    r_hi <= r_count;
                    r_probe_wait <= 1'b0;
                    if (in_kind == KindInsert) begin
                        r_key <= in_start;
                        r_state <= S_PROBE;
                    end else if (in_kind == KindClear) begin
                        r_count <= '0;
                        emit(StCleared, '0);
                    end else if (in_kind == KindLookup && r_lk_en && in_q != 0
                                 && r_count != 0) begin
                        r_key <= q_sw;
                        r_state <= S_PROBE;
                    end else begin
                        emit(StMiss, '0);
                    end
                end
                S_PROBE: begin
                    if (r_lo == r_hi) begin
                        r_state <= S_CHECK;
                    end else if (!r_probe_wait) begin
                        r_probe_wait <= 1'b1;
                    end else begin
                        r_probe_wait <= 1'b0;
                        if (go_right) r_lo <= mid + 1'b1;
                        else          r_hi <= mid;
                    end
                end
                S_CHECK: begin
                    // read issued last cycle only after wait
                    if (!r_probe_wait) begin
                        r_probe_wait <= 1'b1;
                    end else begin
                        r_probe_wait <= 1'b0;
                        if (r_kind == KindLookup) begin
                            if (r_lo != 0 && r_key <= r_rd.r_end) emit(StHit, r_rd);
                            else emit(StMiss, '0);
                        end else if (r_lo < r_count && r_rd.start == r_key) begin
                            r_state <= S_PUT;
                            r_mv <= '1;
                        end else if (r_count == CountW'(TableDepth)) begin
                            emit(StFull, '0);
                        end else begin
                            r_mv <= r_count;
                            r_state <= (r_count == r_lo) ? S_PUT : S_MOVRD;
                        end
                    end
                end
                S_MOVRD: r_state <= S_MOVWR;
                S_MOVWR: begin
                    r_mv <= r_mv - 1'b1;
                    r_state <= (r_mv - 1'b1 == r_lo) ? S_PUT : S_MOVRD;
                end
                S_PUT: begin
                    if (r_mv == '1) begin
                        emit(StReplaced, '0);
                    end else begin
                        emit(StInserted, '0);
                        r_count <= r_count + 1'b1;
                    end
                end
                // hand the result over once the output register is free
                S_DONE: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_ostat  <= r_res_st;
                    r_odata  <= {r_res.r_end, r_res.start, r_res.flag,
                                 r_res.code3, r_res.code2};
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ip range country table: a local table model
// predicts every status word; inserts, replaces, shifting inserts, clear and
// lookups are driven under random stalls on both stream sides
// ----------------------------------------------------------------------------
module tb;
    import iprct_pkg::*;

    localparam int LimitCycles = 10_000_000;

    typedef struct packed {
        logic [31:0] hit_end;
        logic [31:0] hit_start;
        logic [7:0]  hit_flag;
        logic [23:0] hit_code_three;
        logic [15:0] hit_code_two;
        t_status     status;
    } t_lookup_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // kind
    t_kind               s_axis_tuser = KindInsert;
    // range_start, range_end, query_ip, code_two, code_three, flag_number
    logic [InW-1:0]      s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // status
    t_status             m_axis_tuser;
    // hit_code_two, hit_code_three, hit_flag, hit_start, hit_end
    logic [OutW-1:0]     m_axis_tdata;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = 1'b0;
    logic                i_cfg_data = 1'b0;

    ip_range_country_table uut (.*);

    always #4 i_clk = ~i_clk;

    // table model, sorted by start
    t_entry       table_model[$];
    logic         lookup_on, flags_on;
    t_lookup_word expected_words[$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           quiet = 0;     // no idling in the final part
    int           hold_off = 0;  // long receiver stall, in cycles
    int           stall_left = 0;

    function automatic logic [31:0] host_order(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // predict the status word of one input word and update the model
    function automatic t_lookup_word table_predict(t_kind kind, t_entry e, logic [31:0] q);
        t_lookup_word w;
        int pos;
        logic [31:0] h;
        w = '0;
        w.status = StMiss;
        if (kind == KindInsert) begin
            if (!flags_on) e.flag = '0;
            pos = 0;
            while (pos < table_model.size() && table_model[pos].start < e.start) pos++;
            if (pos < table_model.size() && table_model[pos].start == e.start) begin
                table_model[pos] = e;
                w.status = StReplaced;
            end else if (table_model.size() >= TableDepth) begin
                w.status = StFull;
            end else begin
                table_model.insert(pos, e);
                w.status = StInserted;
            end
        end else if (kind == KindClear) begin
            table_model.delete();
            w.status = StCleared;
        end else if (kind == KindLookup && lookup_on && q != 0 && table_model.size() != 0) begin
            h = host_order(q);
            pos = 0;
            while (pos < table_model.size() && table_model[pos].start <= h) pos++;
            if (pos > 0 && h <= table_model[pos-1].r_end) begin
                w.status = StHit;
                w.hit_code_two = table_model[pos-1].code2;
                w.hit_code_three = table_model[pos-1].code3;
                w.hit_flag = table_model[pos-1].flag;
                w.hit_start = table_model[pos-1].start;
                w.hit_end = table_model[pos-1].r_end;
            end
        end
        return w;
    endfunction

    // send one word, with a random gap in front unless quiet
    task automatic send_word(t_kind kind, t_entry e, logic [31:0] q);
        int gap;
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {e.flag, e.code3, e.code2, q, e.r_end, e.start};
        s_axis_tuser <= kind;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_words.push_back(table_predict(kind, e, q));
    endtask

    function automatic t_entry rand_entry(logic [31:0] s, logic [31:0] len);
        t_entry e;
        e.start = s;
        e.r_end = s + len;
        e.code2 = 16'($urandom);
        e.code3 = 24'($urandom);
        e.flag = 8'($urandom);
        return e;
    endfunction

    task automatic insert_range(logic [31:0] s, logic [31:0] len);
        send_word(KindInsert, rand_entry(s, len), '0);
    endtask

    task automatic lookup_addr(logic [31:0] host_addr);
        send_word(KindLookup, '0, host_order(host_addr));
    endtask

    task automatic drain_table;
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // configuration writes only while idle
    task automatic write_reg(logic idx, logic val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == 1'b0) lookup_on = val; else flags_on = val;
        @(posedge i_clk);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(7) == 0) begin
            stall_left <= $urandom_range(11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker: each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_word got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_lookup_word'({m_axis_tdata, m_axis_tuser});
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LimitCycles) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // extremes, disabled lookups, zero query, kind 3, reversed range
    task automatic test_directed;
        t_entry e;
        lookup_addr(32'h0A000001);
        insert_range(32'h0A000000, 32'hFF);
        lookup_addr(32'h0A000010);       // disabled: miss
        drain_table();
        write_reg(1'b0, 1'b1);
        write_reg(1'b1, 1'b1);
        lookup_addr(32'h0A000010);
        send_word(KindLookup, '0, 32'h0);  // zero query
        e = rand_entry(32'h0, 32'h0);
        e.code2 = 16'hFFFF; e.code3 = 24'hFFFFFF; e.flag = 8'hFF;
        send_word(KindInsert, e, '0);
        e = rand_entry(32'hFFFFFFFF, 32'h0);
        send_word(KindInsert, e, '0);
        lookup_addr(32'hFFFFFFFF);
        lookup_addr(32'h01000000);
        send_word(KindInsert, rand_entry(32'h0A000000, 32'h1000), '0); // replace
        lookup_addr(32'h0A000800);
        e = rand_entry(32'h20000000, 32'h0);
        e.r_end = 32'h1FFFFFFF;                // end below start
        send_word(KindInsert, e, '0);
        lookup_addr(32'h20000000);
        send_word(KindReserved, rand_entry(32'h5, 32'h5), 32'h12345678);
        lookup_addr(32'h0A000001);
        send_word(KindClear, '0, '0);
        lookup_addr(32'h0A000001);         // empty table
        drain_table();
    endtask

    // descending inserts shift the whole table, then a replace and lookups
    task automatic test_shift_insert;
        send_word(KindClear, '0, '0);
        for (int i = 79; i >= 0; i--) insert_range(32'(i) << 8, 32'hF);
        insert_range(32'h00000500, 32'h20);  // replace
        for (int i = 0; i < 80; i++) lookup_addr((32'(i) << 8) | 32'(i & 31));
        lookup_addr(32'h00000FF0);           // past the end of the range at 00000F00
        send_word(KindClear, '0, '0);
        drain_table();
    endtask

    // random inserts and lookups near 16 aligned bases, plus some clears and random words
    task automatic test_random(int n);
        logic [31:0] base;
        int r;
        for (int i = 0; i < n; i++) begin
            base = {4'($urandom_range(15)), 28'h0} | 32'($urandom_range(32'h3FF));
            r = $urandom_range(99);
            if (r < 40) insert_range(base, $urandom_range(64));
            else if (r < 93) lookup_addr(base);
            else if (r < 95) send_word(KindClear, '0, '0);
            else if (r < 97) send_word(KindLookup, '0, $urandom);
            else send_word(t_kind'($urandom_range(3)), rand_entry($urandom, $urandom),
                           $urandom);
        end
    endtask

    initial begin
        lookup_on = 0;
        flags_on = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500);
        drain_table();
        write_reg(1'b1, 1'b0);
        hold_off <= 400;   // block fills up and stalls its input
        test_random(400);
        drain_table();
        write_reg(1'b0, 1'b0);
        test_random(100);
        drain_table();
        write_reg(1'b0, 1'b1);
        write_reg(1'b1, 1'b1);
        test_shift_insert();
        quiet = 1;
        test_random(250);
        drain_table();
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
